// ===== sv/mtp_pkg.sv =====
package mtp_pkg;

   // Table geometry
   localparam int unsigned TABLE_WORDS  = 624;
   localparam int unsigned TWIST_OFFSET = 397;
   localparam int unsigned IDX_W        = 10;

   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_WORDS - 1);
   localparam logic [IDX_W-1:0] FAR_STEP   = IDX_W'(TWIST_OFFSET);
   localparam logic [IDX_W-1:0] TABLE_SIZE = IDX_W'(TABLE_WORDS);

   // Generator constants
   localparam logic [31:0] SEED_MULT     = 32'd1812433253;
   localparam logic [31:0] TWIST_MATRIX  = 32'h9908_b0df;
   localparam logic [31:0] HIGH_BIT_MASK = 32'h8000_0000;
   localparam logic [31:0] LOW_BITS_MASK = 32'h7fff_ffff;
   localparam logic [31:0] TEMPER_B      = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C      = 32'hefc6_0000;
   localparam logic [31:0] RESET_SEED    = 32'd5489;

   // Controller states
   typedef enum logic [1:0] {
      ST_FILL,
      ST_IDLE,
      ST_TWIST,
      ST_HOLD
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic fill_step;
      logic accept;
      logic twist;
      logic load_out;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic fill_last;
      logic out_free;
   } status_type;

   // Output tempering of one state word
   function automatic logic [31:0] temper(input logic [31:0] y_in);
      logic [31:0] y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ===== sv/mersenne_twister_prng_unit.sv =====
// MT19937 random number unit.
// Request channel (req_): one beat carries range_low and range_high. For each
// beat the unit twists the next word of its 624-word state table, tempers it,
// and returns one response beat (rsp_) with the tempered raw_word and
// ranged_value = range_low + upper 32 bits of raw_word * (range_high - range_low),
// all modulo 2^32.
// Seed port (csr_): a write of csr_wr_data with csr_wr_en refills the table
// from the new seed; the first draw after it uses the freshly twisted word 0.
// Path: an accepted request is twisted in ST_TWIST, fed by registered table
// reads, and loaded into the output register in ST_HOLD once it is free; a new
// request is taken only in ST_IDLE or in that loading cycle, never in ST_TWIST.
// Reset: the seed returns to 5489 and the table is refilled; req_tready stays
// low during the fill. A seed write starts the same fill.
// Stall: a finished response waits in the output register while rsp_tready is
// low; one more request may be taken and twisted, then req_tready drops
// until the output register frees.
module mersenne_twister_prng_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] range_low, [63:32] range_high
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] raw_word, [63:32] ranged_value
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   mtp_pkg::cmd_type    cmd;
   mtp_pkg::status_type status;
   logic [31:0]         raw_word;
   logic [31:0]         ranged_value;

   mtp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_wr_en  (csr_wr_en),
      .status     (status),
      .cmd        (cmd)
   );

   mtp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .range_low    (req_tdata[31:0]),
      .range_high   (req_tdata[63:32]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .raw_word     (raw_word),
      .ranged_value (ranged_value)
   );

   assign rsp_tdata = {ranged_value, raw_word};

endmodule

// ===== sv/mtp_ctrl.sv =====
module mtp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                csr_wr_en,
   input  mtp_pkg::status_type status,
   output mtp_pkg::cmd_type    cmd
);

   mtp_pkg::state_type state_ff;
   mtp_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtp_pkg::ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtp_pkg::ST_FILL: begin
            if (status.fill_last) begin
               state_in = mtp_pkg::ST_IDLE;
            end
         end
         mtp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = mtp_pkg::ST_TWIST;
            end
         end
         mtp_pkg::ST_TWIST: begin
            state_in = mtp_pkg::ST_HOLD;
         end
         mtp_pkg::ST_HOLD: begin
            if (status.out_free) begin
               state_in = req_tvalid ? mtp_pkg::ST_TWIST : mtp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mtp_pkg::ST_FILL;
         end
      endcase
      // a seed write restarts the table fill from any state
      if (csr_wr_en) begin
         state_in = mtp_pkg::ST_FILL;
      end
   end

   // Outputs
   always_comb begin
      req_tready    = 1'b0;
      cmd.fill_step = 1'b0;
      cmd.twist     = 1'b0;
      cmd.load_out  = 1'b0;
      case (state_ff)
         mtp_pkg::ST_FILL: begin
            cmd.fill_step = 1'b1;
         end
         mtp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         mtp_pkg::ST_TWIST: begin
            cmd.twist = 1'b1;
         end
         mtp_pkg::ST_HOLD: begin
            req_tready   = status.out_free;
            cmd.load_out = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.accept = req_tvalid && req_tready;
   end

`ifndef SYNTH
   // no beat is taken while the table is being filled
   a_no_accept_in_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtp_pkg::ST_FILL) |-> !req_tready)
      else $error("request taken during table fill");

   // every accepted beat without a seed write is twisted in the next cycle
   a_accept_then_twist: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !csr_wr_en) |=> cmd.twist)
      else $error("accepted beat not twisted");

   // a seed write always starts a fill
   a_seed_fills: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (state_ff == mtp_pkg::ST_FILL))
      else $error("seed write did not start fill");

   // a result is loaded only after a twist
   a_load_after_twist: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> $past(cmd.twist) || $past(state_ff == mtp_pkg::ST_HOLD))
      else $error("result loaded without a twist");
`endif

endmodule

// ===== sv/mtp_datapath.sv =====
module mtp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mtp_pkg::cmd_type     cmd,
   output mtp_pkg::status_type  status,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data,
   input  logic [31:0]          range_low,
   input  logic [31:0]          range_high,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          raw_word,
   output logic [31:0]          ranged_value
);

   logic [31:0] table_mem [mtp_pkg::TABLE_WORDS];

   logic [31:0]               seed_ff;
   logic [mtp_pkg::IDX_W-1:0] fill_idx_ff;
   logic [31:0]               prev_ff;
   logic [mtp_pkg::IDX_W-1:0] ptr_ff;
   logic [31:0]               cur_ff;
   logic [31:0]               nxt_rd_ff;
   logic [31:0]               far_rd_ff;
   logic [31:0]               lo_ff;
   logic [31:0]               span_ff;
   logic [31:0]               raw_ff;
   logic [31:0]               prod_hi_ff;
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_raw_ff;
   logic [31:0]               rsp_rng_ff;

   logic [mtp_pkg::IDX_W-1:0] nxt_addr;
   logic [mtp_pkg::IDX_W-1:0] far_sum;
   logic [mtp_pkg::IDX_W-1:0] far_addr;
   logic [mtp_pkg::IDX_W-1:0] ptr_in;
   logic [31:0]               mixed;
   logic [31:0]               mult_lo;
   logic [31:0]               fill_word;
   logic [31:0]               twist_y;
   logic [31:0]               twist_word;
   logic [31:0]               raw_in;
   logic [63:0]               prod;

   // Neighbor and far addresses around the draw pointer
   always_comb begin
      nxt_addr = (ptr_ff == mtp_pkg::LAST_IDX) ? '0 : ptr_ff + 1'b1;
      far_sum  = ptr_ff + mtp_pkg::FAR_STEP;
      far_addr = (far_sum >= mtp_pkg::TABLE_SIZE) ? far_sum - mtp_pkg::TABLE_SIZE : far_sum;
      ptr_in   = nxt_addr;
   end

   // Seeding recurrence, one word per cycle
   always_comb begin
      mixed   = prev_ff ^ (prev_ff >> 30);
      mult_lo = mtp_pkg::SEED_MULT * mixed;
      if (fill_idx_ff == '0) begin
         fill_word = seed_ff;
      end else begin
         fill_word = mult_lo + {{(32 - mtp_pkg::IDX_W){1'b0}}, fill_idx_ff};
      end
   end

   // Twist one word, temper it and scale into the range
   always_comb begin
      twist_y    = (cur_ff & mtp_pkg::HIGH_BIT_MASK) | (nxt_rd_ff & mtp_pkg::LOW_BITS_MASK);
      twist_word = far_rd_ff ^ (twist_y >> 1) ^ (twist_y[0] ? mtp_pkg::TWIST_MATRIX : '0);
      raw_in     = mtp_pkg::temper(twist_word);
      prod       = {32'b0, raw_in} * {32'b0, span_ff};
   end

   // Table memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.fill_step) begin
         table_mem[fill_idx_ff] <= fill_word;
      end else if (cmd.twist) begin
         table_mem[ptr_ff] <= twist_word;
      end
      nxt_rd_ff <= table_mem[nxt_addr];
      far_rd_ff <= table_mem[far_addr];
   end

   // Seed, fill counter and draw pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= mtp_pkg::RESET_SEED;
         fill_idx_ff <= '0;
         ptr_ff      <= '0;
      end else if (csr_wr_en) begin
         seed_ff     <= csr_wr_data;
         fill_idx_ff <= '0;
         ptr_ff      <= '0;
      end else begin
         if (cmd.fill_step) begin
            fill_idx_ff <= (fill_idx_ff == mtp_pkg::LAST_IDX) ? '0 : fill_idx_ff + 1'b1;
         end
         if (cmd.twist) begin
            ptr_ff <= ptr_in;
         end
      end
   end

   // Chain value of the fill and the word under the pointer
   always_ff @(posedge clock) begin
      if (cmd.fill_step) begin
         prev_ff <= fill_word;
         if (fill_idx_ff == '0) begin
            cur_ff <= fill_word;
         end
      end else if (cmd.twist) begin
         cur_ff <= nxt_rd_ff;
      end
   end

   // Capture the request beat and the twist result
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         lo_ff   <= range_low;
         span_ff <= range_high - range_low;
      end
      if (cmd.twist) begin
         raw_ff     <= raw_in;
         prod_hi_ff <= prod[63:32];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_raw_ff <= raw_ff;
         rsp_rng_ff <= lo_ff + prod_hi_ff;
      end
   end

   always_comb begin
      status.fill_last = cmd.fill_step && (fill_idx_ff == mtp_pkg::LAST_IDX);
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign raw_word     = rsp_raw_ff;
   assign ranged_value = rsp_rng_ff;

`ifndef SYNTH
   // the draw pointer stays inside the table
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= mtp_pkg::LAST_IDX)
      else $error("draw pointer out of range");

   // a result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   // fill and twist never write the table together
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fill_step && cmd.twist))
      else $error("two table writers");
`endif

endmodule

// ===== verif/mtp_draw_checker.sv =====
module mtp_draw_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] range_low, [63:32] range_high
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [31:0] raw_word, [63:32] ranged_value
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          mismatch_count,
   output int          draws_pending
);

   typedef struct packed {
      logic [31:0] range_high;
      logic [31:0] range_low;
   } range_req_type;

   typedef struct packed {
      logic [31:0] ranged_value;
      logic [31:0] raw_word;
   } draw_type;

   // Shadow generator state
   logic [31:0] mt_words [mtp_pkg::TABLE_WORDS];
   int unsigned mt_pos;
   draw_type    expected_draws [$];
   int          fails = 0;
   int          pending = 0;

   assign mismatch_count = fails;
   assign draws_pending  = pending;

   // Refill the shadow table from a seed; the next draw twists first
   function automatic void seed_words(input logic [31:0] seed);
      logic [31:0] prev;
      mt_words[0] = seed;
      for (int k = 1; k < mtp_pkg::TABLE_WORDS; k++) begin
         prev        = mt_words[k-1];
         mt_words[k] = mtp_pkg::SEED_MULT * (prev ^ (prev >> 30)) + 32'(k);
      end
      mt_pos = mtp_pkg::TABLE_WORDS;
   endfunction

   // Regenerate all 624 words in place
   function automatic void twist_words();
      logic [31:0] y;
      logic [31:0] mix;
      for (int k = 0; k < mtp_pkg::TABLE_WORDS; k++) begin
         y   = (mt_words[k] & mtp_pkg::HIGH_BIT_MASK) |
               (mt_words[(k + 1) % mtp_pkg::TABLE_WORDS] & mtp_pkg::LOW_BITS_MASK);
         mix = y[0] ? mtp_pkg::TWIST_MATRIX : 32'h0;
         mt_words[k] = mt_words[(k + mtp_pkg::TWIST_OFFSET) % mtp_pkg::TABLE_WORDS] ^
                       (y >> 1) ^ mix;
      end
      mt_pos = 0;
   endfunction

   // Output scrambling of one table word
   function automatic logic [31:0] scramble_word(input logic [31:0] w);
      logic [31:0] s1, s2, s3;
      s1 = w ^ {11'b0, w[31:11]};
      s2 = s1 ^ ({s1[24:0], 7'b0} & mtp_pkg::TEMPER_B);
      s3 = s2 ^ ({s2[16:0], 15'b0} & mtp_pkg::TEMPER_C);
      return s3 ^ {18'b0, s3[31:18]};
   endfunction

   // Take the next word and scale it into the requested range
   function automatic draw_type next_draw(input range_req_type rq);
      draw_type    d;
      logic [31:0] span;
      logic [63:0] prod;
      if (mt_pos >= mtp_pkg::TABLE_WORDS) twist_words();
      d.raw_word = scramble_word(mt_words[mt_pos]);
      mt_pos++;
      span = rq.range_high - rq.range_low;
      prod = {32'h0, d.raw_word} * {32'h0, span};
      d.ranged_value = rq.range_low + prod[63:32];
      return d;
   endfunction

   task automatic note_mismatch(input string what, input draw_type want, input draw_type got);
      if (fails < 10)
         $display("[%0t] %s: raw_word exp %h got %h, ranged_value exp %h got %h",
                   $realtime, what, want.raw_word, got.raw_word,
                   want.ranged_value, got.ranged_value);
      fails++;
   endtask

   // Watch both channels and the seed port
   always @(posedge clock) begin : watch_beats
      draw_type      got;
      draw_type      want;
      range_req_type rq;
      if (reset) begin
         seed_words(mtp_pkg::RESET_SEED);
         expected_draws.delete();
      end else begin
         // Compare a response beat with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_draws.size() == 0) begin
               note_mismatch("response beat with no request pending", '0, got);
            end else begin
               want = expected_draws.pop_front();
               if (got.raw_word !== want.raw_word || got.ranged_value !== want.ranged_value)
                  note_mismatch("response mismatch", want, got);
            end
         end
         // Predict the response of a request beat
         if (req_tvalid && req_tready) begin
            rq = req_tdata;
            expected_draws.push_back(next_draw(rq));
         end
         // Reseed on a register write
         if (csr_wr_en) seed_words(csr_wr_data);
      end
      pending = expected_draws.size();
   end

endmodule

// ===== verif/tb_mersenne_twister_prng_unit.sv =====
module tb_mersenne_twister_prng_unit;

   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [31:0] CORNER_WORDS [6] = '{
      32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
      32'h7fff_ffff, 32'h0000_0001, 32'hffff_fffe
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;   // [31:0] range_low, [63:32] range_high
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;          // [31:0] raw_word, [63:32] ranged_value
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   int mismatch_count;
   int draws_pending;
   bit hold_asked = 1'b0;
   bit hold_done  = 1'b0;

   mersenne_twister_prng_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   mtp_draw_checker draw_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .draws_pending (draws_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // End the run when nothing moves for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(negedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
            idle = 0;
         else
            idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Response side: changing stall patterns, plus one long hold-off on request
   initial begin : rsp_side
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_asked && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(16, 120);
            end
            left--;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               2:       rsp_tready <= (left % 4 != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offer one range beat and hold it until it is taken
   task automatic offer_range(input logic [31:0] lo, input logic [31:0] hi);
      bit took;
      req_tdata  <= {hi, lo};
      req_tvalid <= 1'b1;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
   endtask

   // Pick a random range, weighted toward the wrap and zero-span cases
   function automatic logic [63:0] random_range();
      logic [31:0] lo, hi, t;
      lo = $urandom;
      hi = $urandom;
      case ($urandom_range(0, 9))
         4: hi = lo;
         5: if (hi > lo) begin
               t  = hi;
               hi = lo;
               lo = t;
            end
         6: hi = lo + $urandom_range(0, 255);
         7: begin
               lo = CORNER_WORDS[$urandom_range(0, 5)];
               hi = CORNER_WORDS[$urandom_range(0, 5)];
            end
         8: lo = '0;
         9: hi = 32'hffff_ffff;
         default: ;
      endcase
      return {hi, lo};
   endfunction

   // Send random beats in bursts with random gaps
   task automatic pump_ranges(input int count);
      int          left, burst, gap;
      logic [63:0] rq;
      left = count;
      while (left > 0) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
         if (burst > left) burst = left;
         repeat (burst) begin
            rq = random_range();
            offer_range(rq[31:0], rq[63:32]);
         end
         left -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and wait for every response to come back
   task automatic drain_draws();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (draws_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write a new seed once the unit is idle
   task automatic reseed(input logic [31:0] seed);
      drain_draws();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= seed;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed ranges on the reset seed
      offer_range(32'h0000_0000, 32'h0000_0000);
      offer_range(32'h0000_0000, 32'hffff_ffff);
      offer_range(32'hffff_ffff, 32'h0000_0000);
      offer_range(32'hffff_ffff, 32'hffff_ffff);
      offer_range(32'h8000_0000, 32'h7fff_ffff);
      offer_range(32'h7fff_ffff, 32'h8000_0000);
      offer_range(32'h0000_0001, 32'h0000_0000);
      offer_range(32'h0000_0000, 32'h0000_0001);
      offer_range(32'd1000, 32'd1000);
      offer_range(32'd100, 32'd200);
      offer_range(32'd200, 32'd100);
      offer_range(32'h5555_5555, 32'haaaa_aaaa);
      offer_range(32'haaaa_aaaa, 32'h5555_5555);
      offer_range(32'hffff_fff0, 32'h0000_0010);
      pump_ranges(100);

      // Extreme seeds
      reseed(32'h0000_0000);
      pump_ranges(150);
      reseed(32'hffff_ffff);
      pump_ranges(150);

      // Random seed, long enough to twist twice; start the long response
      // hold-off once the fill is over so that requests back up
      reseed($urandom);
      pump_ranges(20);
      hold_asked = 1'b1;
      pump_ranges(630);

      reseed(32'h0000_0001);
      pump_ranges(50);

      drain_draws();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && draws_pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/mtp_pkg.sv
sv/mtp_ctrl.sv
sv/mtp_datapath.sv
sv/mersenne_twister_prng_unit.sv
verif/mtp_draw_checker.sv
verif/tb_mersenne_twister_prng_unit.sv
